@@ rtl/dosf_pkg.sv @@
// Package for the drop-oldest sample FIFO.
// Holds field widths, command and status codes, and the decoded-op and result types.
// No dependencies.
package dosf_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int BLEN_W    = 16;
  localparam int REQ_W     = 7;
  localparam int FILL_W    = 11;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'b1;

  localparam int CAP_RESET = 1024;
  localparam int WIN_RESET = 512;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_EMPTY  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_REPORT = 2'd0,
    OP_STORE  = 2'd1,
    OP_GET    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_kind_t;

  typedef struct packed {
    op_kind_t                    kind;
    status_t                     status;
    logic signed [SAMPLE_W-1:0]  sample;
    logic        [REQ_W-1:0]     req;
  } op_t;

  typedef struct packed {
    status_t                     status;
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic                        sample_valid;
    logic                        in_window;
    logic        [REQ_W-1:0]     taken_count;
    logic        [FILL_W-1:0]    fill_level;
    logic                        last;
  } res_t;

endpackage

@@ rtl/dosf_front.sv @@
// Front decoder of the drop-oldest sample FIFO.
// Classifies each input transaction into a decoded op; uses dosf_pkg.
module dosf_front
  import dosf_pkg::*;
#(
  parameter int MAX_BURST = 64
) (
  input  logic        [CMD_W-1:0]    command,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic        [BLEN_W-1:0]   block_len,
  input  logic        [REQ_W-1:0]    request_count,
  input  logic        [FILL_W-1:0]   eff_cap,
  output op_t                        op
);

  localparam logic [REQ_W-1:0] BURST_MAX = REQ_W'(MAX_BURST);

  logic too_long;

  assign too_long = block_len > BLEN_W'(eff_cap);

  always_comb begin
    op.kind   = OP_REPORT;
    op.status = STAT_OK;
    op.sample = sample;
    op.req    = (request_count > BURST_MAX) ? BURST_MAX : request_count;
    case (command)
      CMD_PUSH: begin
        if (too_long) begin
          op.status = STAT_REJECT;
        end else if (block_len != '0) begin
          op.kind = OP_STORE;
        end
      end
      CMD_GET: begin
        op.kind = OP_GET;
      end
      CMD_CLEAR: begin
        op.kind = OP_CLEAR;
      end
      default: begin
        op.kind = OP_REPORT;
      end
    endcase
  end

endmodule

@@ rtl/dosf_queue.sv @@
// Two-entry op queue between front decoder and back end.
// Decouples input stall from back-end progress; uses dosf_pkg.
module dosf_queue
  import dosf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output op_t  head_op
);

  op_t        entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = count == 2'd2;
  assign head_valid = count != 2'd0;
  assign head_op    = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ rtl/dosf_back.sv @@
// Back end of the drop-oldest sample FIFO: sample memory, pointers, registers,
// get sequencer and two-entry result buffer. Uses dosf_pkg.
module dosf_back
  import dosf_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  op_t                   q_op,
  output logic                  q_pop,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [FILL_W-1:0]     cfg_data,
  output logic [FILL_W-1:0]     eff_cap,
  input  logic                  out_stall,
  output logic                  out_valid,
  output res_t                  out_res
);

  localparam int PTR_W     = $clog2(DEPTH);
  localparam int SUM_W     = ((PTR_W > FILL_W) ? PTR_W : FILL_W) + 1;
  localparam int CAP_LIMIT = (DEPTH < 2047) ? DEPTH : 2047;
  localparam int CAP_RST   = (CAP_RESET < CAP_LIMIT) ? CAP_RESET : CAP_LIMIT;

  localparam logic [FILL_W-1:0] CAP_MAX  = FILL_W'(CAP_LIMIT);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [SUM_W-1:0]  DEPTH_S  = SUM_W'(DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_GET  = 2'b10
  } state_t;

  logic signed [SAMPLE_W-1:0] mem [DEPTH];

  state_t                     state, state_next;
  logic        [PTR_W-1:0]    rp, rp_next;
  logic        [FILL_W-1:0]   fill, fill_next;
  logic        [FILL_W-1:0]   win_len;
  logic        [REQ_W-1:0]    n_reg, n_next;
  logic        [REQ_W-1:0]    k, k_next;
  logic                       s1_valid, issue;
  res_t                       s1, s1_next;
  res_t                       s1_done;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic                       rd_en;
  logic                       wr_en;
  logic        [PTR_W-1:0]    wr_addr;

  res_t                       ob [2];
  logic                       ob_wr;
  logic                       ob_rd;
  logic        [1:0]          ob_cnt;
  logic                       pop;
  logic        [1:0]          occ;
  logic                       can_issue;

  logic        [PTR_W-1:0]    rp_inc;
  logic                       full;
  logic        [PTR_W-1:0]    base;
  logic        [FILL_W-1:0]   fill_pre;
  logic        [SUM_W-1:0]    addr_sum;
  logic        [REQ_W-1:0]    get_n;
  logic        [REQ_W-1:0]    remain;
  logic                       cap_wr;

  assign pop       = (ob_cnt != 2'd0) && !out_stall;
  assign occ       = ob_cnt + {1'b0, s1_valid} - {1'b0, pop};
  assign can_issue = occ < 2'd2;

  assign rp_inc   = (rp == PTR_LAST) ? '0 : rp + PTR_W'(1);
  assign full     = fill >= eff_cap;
  assign base     = full ? rp_inc : rp;
  assign fill_pre = full ? eff_cap - FILL_W'(1) : fill;
  assign addr_sum = SUM_W'(base) + SUM_W'(fill_pre);
  assign wr_addr  = (addr_sum >= DEPTH_S) ? PTR_W'(addr_sum - DEPTH_S) : PTR_W'(addr_sum);

  assign get_n  = (FILL_W'(q_op.req) < fill) ? q_op.req : fill[REQ_W-1:0];
  assign remain = n_reg - k;
  assign cap_wr = cfg_valid && (cfg_index == REG_CAPACITY);

  always_comb begin
    state_next = state;
    rp_next    = rp;
    fill_next  = fill;
    n_next     = n_reg;
    k_next     = k;
    issue      = 1'b0;
    q_pop      = 1'b0;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    s1_next    = s1;
    case (state)
      ST_IDLE: begin
        if (q_valid && can_issue) begin
          q_pop   = 1'b1;
          issue   = 1'b1;
          s1_next = '{status: q_op.status, sample_out: '0, sample_valid: 1'b0,
                      in_window: 1'b0, taken_count: '0, fill_level: fill, last: 1'b1};
          case (q_op.kind)
            OP_STORE: begin
              wr_en              = 1'b1;
              rp_next            = base;
              fill_next          = fill_pre + FILL_W'(1);
              s1_next.fill_level = fill_pre + FILL_W'(1);
            end
            OP_CLEAR: begin
              fill_next          = '0;
              s1_next.fill_level = '0;
            end
            OP_GET: begin
              if (get_n == '0) begin
                s1_next.status = STAT_EMPTY;
              end else begin
                rd_en                = 1'b1;
                rp_next              = rp_inc;
                fill_next            = fill - FILL_W'(get_n);
                s1_next.fill_level   = fill - FILL_W'(get_n);
                s1_next.sample_valid = 1'b1;
                s1_next.in_window    = FILL_W'(get_n) <= win_len;
                s1_next.taken_count  = get_n;
                s1_next.last         = get_n == REQ_W'(1);
                n_next               = get_n;
                k_next               = REQ_W'(1);
                if (get_n != REQ_W'(1)) begin
                  state_next = ST_GET;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_GET: begin
        if (can_issue) begin
          issue                = 1'b1;
          rd_en                = 1'b1;
          rp_next              = rp_inc;
          k_next               = k + REQ_W'(1);
          s1_next.in_window    = FILL_W'(remain) <= win_len;
          s1_next.last         = remain == REQ_W'(1);
          if (remain == REQ_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (cap_wr) begin
      fill_next = '0;
      rp_next   = '0;
    end
  end

  always_comb begin
    s1_done            = s1;
    s1_done.sample_out = s1.sample_valid ? rd_data : '0;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_op.sample;
    end
    if (rd_en) begin
      rd_data <= mem[rp];
    end
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
    if (s1_valid) begin
      ob[ob_wr] <= s1_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      rp       <= '0;
      fill     <= '0;
      n_reg    <= '0;
      k        <= '0;
      s1_valid <= 1'b0;
      eff_cap  <= FILL_W'(CAP_RST);
      win_len  <= FILL_W'(WIN_RESET);
      ob_wr    <= 1'b0;
      ob_rd    <= 1'b0;
      ob_cnt   <= 2'd0;
    end else begin
      state    <= state_next;
      rp       <= rp_next;
      fill     <= fill_next;
      n_reg    <= n_next;
      k        <= k_next;
      s1_valid <= issue;
      if (cap_wr) begin
        eff_cap <= (cfg_data > CAP_MAX) ? CAP_MAX : cfg_data;
      end
      if (cfg_valid && (cfg_index == REG_WINDOW_LEN)) begin
        win_len <= cfg_data;
      end
      if (s1_valid) begin
        ob_wr <= ~ob_wr;
      end
      if (pop) begin
        ob_rd <= ~ob_rd;
      end
      ob_cnt <= ob_cnt + {1'b0, s1_valid} - {1'b0, pop};
    end
  end

  assign out_valid = ob_cnt != 2'd0;
  assign out_res   = ob[ob_rd];

endmodule

@@ rtl/drop_oldest_sample_fifo_core.sv @@
// Drop-oldest sample FIFO, top level. Uses dosf_pkg, dosf_front, dosf_queue, dosf_back.
// An input transaction passes through the op queue, the s1 stage and the result buffer.
// Push, clear and other single-result commands issue one result each; a get taking n
// samples takes n memory reads in the get sequencer, pausing on a full result buffer.
// Reset: synchronous, active high; empties FIFO, capacity min(1024, DEPTH), window 512.
// Sample memory is not cleared; only written entries are read.
module drop_oldest_sample_fifo_core
  import dosf_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int MAX_BURST = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic        [CMD_W-1:0]     command,
  input  logic signed [SAMPLE_W-1:0]  sample,
  input  logic        [BLEN_W-1:0]    block_len,
  input  logic        [REQ_W-1:0]     request_count,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic        [STATUS_W-1:0]  status,
  output logic signed [SAMPLE_W-1:0]  sample_out,
  output logic                        sample_valid,
  output logic                        in_window,
  output logic        [REQ_W-1:0]     taken_count,
  output logic        [FILL_W-1:0]    fill_level,
  output logic                        last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic        [CFG_IDX_W-1:0] cfg_index,
  input  logic        [FILL_W-1:0]    cfg_data
);

  op_t               front_op;
  op_t               head_op;
  logic              head_valid;
  logic              head_pop;
  logic              q_full;
  logic [FILL_W-1:0] eff_cap;
  res_t              res;

  assign in_stall  = q_full;
  assign cfg_ready = 1'b1;

  dosf_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .command       (command),
    .sample        (sample),
    .block_len     (block_len),
    .request_count (request_count),
    .eff_cap       (eff_cap),
    .op            (front_op)
  );

  dosf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && !q_full),
    .push_op    (front_op),
    .full       (q_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  dosf_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (head_valid),
    .q_op      (head_op),
    .q_pop     (head_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .eff_cap   (eff_cap),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign status       = res.status;
  assign sample_out   = res.sample_out;
  assign sample_valid = res.sample_valid;
  assign in_window    = res.in_window;
  assign taken_count  = res.taken_count;
  assign fill_level   = res.fill_level;
  assign last         = res.last;

endmodule
